@@ rtl/npgrd_pkg.sv @@
// Package for the nine-patch guide run detector.
// Holds widths, reset values, types and the position helper; depends on nothing.
`timescale 1ns / 1ps

package npgrd_pkg;

   // Longest guide line before positions saturate
   localparam int unsigned LINE_MAX     = 4096;
   // Pixel counter must hold LINE_MAX itself
   localparam int unsigned CNT_W        = $clog2(LINE_MAX + 1);
   // Positions stop at LINE_MAX-1
   localparam int unsigned POS_W        = $clog2(LINE_MAX);
   localparam int unsigned RUN_POS_W    = 12;
   localparam int unsigned PIXEL_W      = 32;
   localparam logic [PIXEL_W-1:0] MARKER_RESET = 32'h0000_00FF;

   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [POS_W-1:0]     pos_type;
   typedef logic [RUN_POS_W-1:0] run_pos_type;
   typedef logic [PIXEL_W-1:0]   pixel_type;

   // Report a position in the result field, wrapping modulo the field width
   function automatic run_pos_type to_run_pos(input pos_type pos);
      logic [31:0] wide;
      wide = 32'(pos);
      return wide[RUN_POS_W-1:0];
   endfunction

endpackage

@@ rtl/npgrd_if.sv @@
// Channel interfaces of the nine-patch guide run detector: pixel, run and marker.
// Depends on npgrd_pkg for the payload types.
`timescale 1ns / 1ps

interface npgrd_req_if
   import npgrd_pkg::*;
   ();
   logic      valid;
   logic      ready;
   pixel_type pixel;
   logic      line_last;

   modport source (output valid, output pixel, output line_last, input ready);
   modport sink   (input valid, input pixel, input line_last, output ready);
endinterface

interface npgrd_rsp_if
   import npgrd_pkg::*;
   ();
   logic        valid;
   logic        ready;
   run_pos_type run_start;
   run_pos_type run_end;
   logic        run_kind;
   logic        start_with_stretch;
   logic        discard_fixed;
   logic        line_done;
   logic        overflow;

   modport source (output valid, output run_start, output run_end, output run_kind,
                   output start_with_stretch, output discard_fixed, output line_done,
                   output overflow, input ready);
   modport sink   (input valid, input run_start, input run_end, input run_kind,
                   input start_with_stretch, input discard_fixed, input line_done,
                   input overflow, output ready);
endinterface

interface npgrd_csr_if
   import npgrd_pkg::*;
   ();
   logic      valid;
   logic      ready;
   pixel_type marker_pixel;

   modport source (output valid, output marker_pixel, input ready);
   modport sink   (input valid, input marker_pixel, output ready);
endinterface

@@ rtl/nine_patch_guide_run_detector_unit.sv @@
// Nine-patch guide run detector, top level.
// Depends on npgrd_pkg and the channel interfaces in npgrd_if.sv.
//
// Feed the border pixels of one guide line, one pixel per item, with line_last on the
// final pixel. The first and last positions are skipped; the interior is split into runs
// of equal pixels, a run equal to the marker register being a stretch run. Each run comes
// out as one item when it closes; a line without a stretch run ends with one replacement
// stretch run 1..length-1 flagged discard_fixed. The block takes one pixel every cycle
// while the result register is free or draining; a run item enters the result register in
// the cycle after the pixel that closes it, and a new pixel is taken while that item waits,
// as long as the result register is empty or being drained in the same cycle. The marker
// write port is always ready and should only be written between lines.
`timescale 1ns / 1ps

module nine_patch_guide_run_detector_unit
   import npgrd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   npgrd_req_if.sink        req_chan,
   npgrd_rsp_if.source      rsp_chan,
   npgrd_csr_if.sink        csr_chan
);

   // Line state
   pixel_type   marker_ff,   marker_in;
   cnt_type     count_ff,    count_in;
   pixel_type   prev_ff,     prev_in;
   pos_type     begin_ff,    begin_in;
   logic        seen_ff,     seen_in;
   logic        starts_ff,   starts_in;
   logic        ovf_ff,      ovf_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   run_pos_type start_ff,     start_in;
   run_pos_type end_ff,       end_in;
   logic        kind_ff,      kind_in;
   logic        sws_ff,       sws_in;
   logic        disc_ff,      disc_in;
   logic        done_ff,      done_in;
   logic        rovf_ff,      rovf_in;

   logic        take;
   logic        sat;
   pos_type     pos;
   logic        ovf_now;
   logic        prev_is_marker;
   logic        emit;

   // Accept a pixel whenever the result register is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // Marker register
   always_comb begin
      marker_in = marker_ff;
      if (csr_chan.valid) begin
         marker_in = csr_chan.marker_pixel;
      end
   end

   // Position of this pixel, saturated at the end of a long line
   assign sat            = (count_ff == cnt_type'(LINE_MAX));
   assign pos            = sat ? pos_type'(LINE_MAX - 1) : count_ff[POS_W-1:0];
   assign ovf_now        = ovf_ff || sat;
   assign prev_is_marker = (prev_ff == marker_ff);

   // Run splitting for one accepted pixel
   always_comb begin
      count_in  = count_ff;
      prev_in   = prev_ff;
      begin_in  = begin_ff;
      seen_in   = seen_ff;
      starts_in = starts_ff;
      ovf_in    = ovf_ff;
      emit      = 1'b0;
      start_in  = to_run_pos(begin_ff);
      end_in    = to_run_pos(pos);
      kind_in   = prev_is_marker;
      sws_in    = starts_ff;
      disc_in   = 1'b0;
      done_in   = 1'b0;
      rovf_in   = ovf_now;
      if (take) begin
         count_in = sat ? count_ff : count_ff + cnt_type'(1);
         ovf_in   = ovf_now;
         if (!req_chan.line_last) begin
            if (pos == pos_type'(1)) begin
               // open the first interior run
               begin_in  = pos_type'(1);
               prev_in   = req_chan.pixel;
               starts_in = (req_chan.pixel == marker_ff);
               seen_in   = 1'b0;
            end else if (pos != '0 && req_chan.pixel != prev_ff) begin
               // close the run and open the next
               emit     = 1'b1;
               seen_in  = seen_ff || prev_is_marker;
               begin_in = pos;
               prev_in  = req_chan.pixel;
            end
         end else begin
            // line end: close the open run or fall back, then clear the line
            if (pos > pos_type'(1)) begin
               emit    = 1'b1;
               done_in = 1'b1;
               if (!prev_is_marker && !seen_ff) begin
                  start_in = to_run_pos(pos_type'(1));
                  kind_in  = 1'b1;
                  sws_in   = 1'b1;
                  disc_in  = 1'b1;
               end
            end
            count_in  = '0;
            prev_in   = '0;
            begin_in  = pos_type'(1);
            seen_in   = 1'b0;
            starts_in = 1'b0;
            ovf_in    = 1'b0;
         end
      end
   end

   // Hold a waiting result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and line state
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff    <= MARKER_RESET;
         count_ff     <= '0;
         prev_ff      <= '0;
         begin_ff     <= pos_type'(1);
         seen_ff      <= 1'b0;
         starts_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         marker_ff    <= marker_in;
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         begin_ff     <= begin_in;
         seen_ff      <= seen_in;
         starts_ff    <= starts_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload, loaded only with a new item
   always_ff @(posedge clock) begin
      if (emit) begin
         start_ff <= start_in;
         end_ff   <= end_in;
         kind_ff  <= kind_in;
         sws_ff   <= sws_in;
         disc_ff  <= disc_in;
         done_ff  <= done_in;
         rovf_ff  <= rovf_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.run_start          = start_ff;
   assign rsp_chan.run_end            = end_ff;
   assign rsp_chan.run_kind           = kind_ff;
   assign rsp_chan.start_with_stretch = sws_ff;
   assign rsp_chan.discard_fixed      = disc_ff;
   assign rsp_chan.line_done          = done_ff;
   assign rsp_chan.overflow           = rovf_ff;

   // Counter never passes the saturation point
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(LINE_MAX))
      else $error("pixel counter beyond line limit");

   // Overflow is only flagged once the counter has saturated
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> sat)
      else $error("overflow set without saturated counter");

   // A line end clears the line state
   assert property (@(posedge clock) disable iff (reset)
      take && req_chan.line_last |=> count_ff == '0 && !seen_ff && !ovf_ff)
      else $error("line state not cleared after line end");

   // A fallback item is a line-closing stretch run from position one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && disc_ff |-> kind_ff && sws_ff && done_ff
                                  && start_ff == to_run_pos(pos_type'(1)))
      else $error("malformed fallback run");

   // A waiting result is never overwritten by a new one
   assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("result overwritten while stalled");

endmodule
